// File: hdl/qcqd_pkg.sv
package qcqd_pkg;

    localparam int CHANNELS_DEFAULT    = 4;
    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int PHASE_WIDTH         = 4;
    localparam int SPEED_WIDTH         = 16;
    localparam int NUM_OUT             = 4;
    localparam int MASK_WIDTH          = 4;

    localparam logic [MASK_WIDTH-1:0] INVERT_MASK_RESET = 4'd6;

    typedef enum logic
    {
        CMD_SAMPLE  = 1'b0,
        CMD_CAPTURE = 1'b1
    } command_t;

    typedef enum logic [1:0]
    {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd3
    } step_t;

    typedef struct packed
    {
        logic sample_en;
        logic capture_en;
    } lane_ctrl_t;

    // Indexed by previous reading * 4 + reading; double steps count nothing.
    localparam step_t STEP_TABLE [16] = '{
        STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE,
        STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
        STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
        STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE
    };

    function automatic step_t step_lookup(input logic [1:0] previous, input logic [1:0] reading);
        return STEP_TABLE[{previous, reading}];
    endfunction

endpackage

// File: hdl/quad_channel_quadrature_decoder_core.sv
// Four-channel 4x quadrature counter. A sample transaction (command 0) steps every channel's
// tick counter by +1, -1 or 0 from its previous and current phase reading; a capture
// transaction (command 1) copies every count, negated where invert_mask selects the channel,
// into the output register and clears the counts. One input transaction is taken every clock
// cycle unless a capture waits; the per-channel counters are registers updated by each taken
// transaction, and a capture result is presented the cycle after its transaction. Samples
// never stall; a capture waits only while the output register holds a result not yet taken.
module quad_channel_quadrature_decoder_core
#(
    parameter int CHANNELS    = qcqd_pkg::CHANNELS_DEFAULT,
    parameter int COUNT_WIDTH = qcqd_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [qcqd_pkg::MASK_WIDTH-1:0]          cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic                                     command,
    input  logic [qcqd_pkg::PHASE_WIDTH-1:0]         phase_a,
    input  logic [qcqd_pkg::PHASE_WIDTH-1:0]         phase_b,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [qcqd_pkg::SPEED_WIDTH-1:0]  speed_ch0,
    output logic signed [qcqd_pkg::SPEED_WIDTH-1:0]  speed_ch1,
    output logic signed [qcqd_pkg::SPEED_WIDTH-1:0]  speed_ch2,
    output logic signed [qcqd_pkg::SPEED_WIDTH-1:0]  speed_ch3
);
    import qcqd_pkg::*;

    logic [MASK_WIDTH-1:0]                invert_mask_reg;
    logic [MASK_WIDTH-1:0]                invert_mask_next;
    logic                                 in_accept;
    logic                                 is_capture;
    lane_ctrl_t                           lane_ctrl;
    logic [CHANNELS-1:0][COUNT_WIDTH-1:0] lane_value;
    logic [CHANNELS-1:0][COUNT_WIDTH-1:0] lane_count;
    logic [NUM_OUT-1:0][SPEED_WIDTH-1:0]  speed;

    assign cfg_ready        = 1'b1;
    assign invert_mask_next = (cfg_valid && cfg_ready) ? cfg_data : invert_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_mask_reg <= INVERT_MASK_RESET;
        end
        else
        begin
            invert_mask_reg <= invert_mask_next;
        end
    end

    assign is_capture           = (command == CMD_CAPTURE);
    assign in_ready             = !is_capture || !out_valid || out_ready;
    assign in_accept            = in_valid && in_ready;
    assign lane_ctrl.sample_en  = in_accept && !is_capture;
    assign lane_ctrl.capture_en = in_accept && is_capture;

    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++)
        begin : g_lane
            logic lane_a;
            logic lane_b;
            logic lane_invert;

            if (c < PHASE_WIDTH)
            begin : g_pins
                assign lane_a      = phase_a[c];
                assign lane_b      = phase_b[c];
                assign lane_invert = invert_mask_reg[c];
            end
            else
            begin : g_no_pins
                assign lane_a      = 1'b0;
                assign lane_b      = 1'b0;
                assign lane_invert = 1'b0;
            end

            qcqd_lane
            #(
                .COUNT_WIDTH (COUNT_WIDTH)
            )
            u_lane
            (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (lane_ctrl),
                .phase_a       (lane_a),
                .phase_b       (lane_b),
                .invert        (lane_invert),
                .capture_value (lane_value[c]),
                .count         (lane_count[c])
            );
        end
    endgenerate

    qcqd_merge
    #(
        .CHANNELS    (CHANNELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (lane_ctrl.capture_en),
        .lane_value (lane_value),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .speed      (speed)
    );

    assign speed_ch0 = speed[0];
    assign speed_ch1 = speed[1];
    assign speed_ch2 = speed[2];
    assign speed_ch3 = speed[3];

`ifndef NO_ASSERTIONS
    a_capture_gives_result : assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && command == CMD_CAPTURE) |=> out_valid
    ) else $error("A capture transaction did not produce a result.");

    a_capture_clears_counts : assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && command == CMD_CAPTURE) |=> (lane_count == '0)
    ) else $error("Counts were not cleared by a capture transaction.");

    a_stall_only_when_full : assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (command == CMD_CAPTURE && out_valid && !out_ready)
    ) else $error("Input stalled without a pending result.");
`endif

endmodule

// File: hdl/qcqd_lane.sv
module qcqd_lane
#(
    parameter int COUNT_WIDTH = qcqd_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  qcqd_pkg::lane_ctrl_t   ctrl,
    input  logic                   phase_a,
    input  logic                   phase_b,
    input  logic                   invert,
    output logic [COUNT_WIDTH-1:0] capture_value,
    output logic [COUNT_WIDTH-1:0] count
);
    import qcqd_pkg::*;

    logic [1:0]             last_reading_reg;
    logic [1:0]             last_reading_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [1:0]             reading;
    step_t                  step;

    assign reading = {phase_a, phase_b};
    assign step    = step_lookup(last_reading_reg, reading);

    always_comb
    begin
        last_reading_next = last_reading_reg;
        count_next        = count_reg;
        if (ctrl.capture_en)
        begin
            count_next = '0;
        end
        else if (ctrl.sample_en)
        begin
            last_reading_next = reading;
            case (step)
                STEP_UP:   count_next = count_reg + COUNT_WIDTH'(1);
                STEP_DOWN: count_next = count_reg - COUNT_WIDTH'(1);
                default:   count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reading_reg <= '0;
            count_reg        <= '0;
        end
        else
        begin
            last_reading_reg <= last_reading_next;
            count_reg        <= count_next;
        end
    end

    assign capture_value = invert ? (~count_reg + COUNT_WIDTH'(1)) : count_reg;
    assign count         = count_reg;

endmodule

// File: hdl/qcqd_merge.sv
module qcqd_merge
#(
    parameter int CHANNELS    = qcqd_pkg::CHANNELS_DEFAULT,
    parameter int COUNT_WIDTH = qcqd_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       load,
    input  logic [CHANNELS-1:0][COUNT_WIDTH-1:0]       lane_value,
    input  logic                                       out_ready,
    output logic                                       out_valid,
    output logic [qcqd_pkg::NUM_OUT-1:0][qcqd_pkg::SPEED_WIDTH-1:0] speed
);
    import qcqd_pkg::*;

    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic [NUM_OUT-1:0][SPEED_WIDTH-1:0]    speed_reg;
    logic [NUM_OUT-1:0][SPEED_WIDTH-1:0]    speed_next;

    genvar o;
    generate
        for (o = 0; o < NUM_OUT; o++)
        begin : g_out
            if (o < CHANNELS)
            begin : g_built
                logic [SPEED_WIDTH+COUNT_WIDTH-1:0] extended;
                assign extended      = {{SPEED_WIDTH{1'b0}}, lane_value[o]};
                assign speed_next[o] = extended[SPEED_WIDTH-1:0];
            end
            else
            begin : g_absent
                assign speed_next[o] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            speed_reg <= speed_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign speed     = speed_reg;

endmodule
